// ===== rtl/rem_pkg.sv =====
// shared types, constants and codes for the robust ewma t2 monitor
// no dependencies; used by rem_front, rem_back and robust_ewma_t2_monitor
package rem_pkg;

  localparam int IDX_W       = 4;
  localparam int VAL_W       = 32;
  localparam int T2_W        = 48;
  localparam int RL_W        = 16;
  localparam int LAM_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 72;
  localparam int ACC_W       = 56;
  localparam int QDEPTH      = 4;
  localparam int NUM_VARS_DEF  = 16;
  localparam int NUM_COMPS_DEF = 16;

  localparam logic [LAM_W-1:0]      LAMBDA_RST = 17'd13107;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RST  = 48'd65536;
  localparam logic [T2_W-1:0]       T2_MAX     = {T2_W{1'b1}};
  localparam logic [RL_W-1:0]       RL_MAX     = {RL_W{1'b1}};

  typedef enum logic [2:0] {
    REQ_SAMPLE   = 3'd0,
    REQ_LOAD_K   = 3'd1,
    REQ_LOAD_KI  = 3'd2,
    REQ_LOAD_VEC = 3'd3,
    REQ_LOAD_EVI = 3'd4,
    REQ_RESTART  = 3'd5
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA = 2'd0,
    CFG_HUBER  = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    PHI_ADD,
    PHI_SUB,
    PHI_PROD,
    PHI_ERR
  } phi_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SC,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_B5,
    ST_FIN,
    ST_PROJ,
    ST_T_SQ,
    ST_T_M1,
    ST_T_M2,
    ST_T_ACC,
    ST_RES
  } st_e;

  typedef struct packed {
    req_e                     op;
    logic [IDX_W-1:0]         vidx;
    logic [IDX_W-1:0]         cidx;
    logic signed [VAL_W-1:0]  value;
    logic                     last;
    logic                     warmup;
  } cmd_t;

  typedef struct packed {
    logic [T2_W-1:0] t2_stat;
    logic            alarm;
    logic [RL_W-1:0] run_length;
    logic            was_warmup;
  } res_t;

endpackage

// ===== rtl/robust_ewma_t2_monitor.sv =====
// top level of the robust ewma t2 monitor: front queue, back sequencer, output register
// depends on rem_pkg, rem_front, rem_back
//
// Input stream: one beat per sample element, table load or restart. tuser carries the request
// kind and the warm-up flag, tlast marks the last variable of an observation, tdata
// the variable index, component index and Q16.16 value. Loads and restart give no
// output. Each beat naming a variable or component out of range is dropped.
// Output stream: one beat per closed observation with T2, alarm and run length.
// A sample element passes the error step, the score update (skipped on zero error, with
// extra steps for the in-band non-Huber score) and the projection over all
// components; the closing element adds the T2 sum. These steps share one multiplier.
// A four-entry command queue lets input beats be taken while the sequencer works,
// and an output register holds a finished result while the receiver stalls; the
// sequencer waits only when that register is still full.
// Reset clears the EWMA values, projections, run length and alarm latch and sets the
// configuration registers to their defaults; the k, 1/k, eigenvector and eigenvalue
// tables keep whatever they held and must be loaded before use.
module robust_ewma_t2_monitor #(
  parameter int NUM_VARS  = rem_pkg::NUM_VARS_DEF,
  parameter int NUM_COMPS = rem_pkg::NUM_COMPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // var_index[3:0], comp_index[7:4], value[39:8]
  input  logic [rem_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // req_type[2:0], warmup[3]
  input  logic [rem_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // t2_stat[47:0], alarm[48], run_length[64:49], zero fill above
  output logic [rem_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // was_warmup[0]
  output logic                            m_axis_tuser_o
);

  logic          cmd_valid, cmd_ready;
  rem_pkg::cmd_t cmd;
  logic          res_valid, res_ready;
  rem_pkg::res_t res;
  logic          out_valid_q;
  rem_pkg::res_t out_q;

  rem_front #(.NUM_VARS(NUM_VARS), .NUM_COMPS(NUM_COMPS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  rem_back #(.NUM_VARS(NUM_VARS), .NUM_COMPS(NUM_COMPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q.run_length, out_q.alarm, out_q.t2_stat};
  assign m_axis_tuser_o  = out_q.was_warmup;

endmodule

// ===== rtl/rem_front.sv =====
// front end: decodes input beats, drops ignored requests, queues commands
// depends on rem_pkg
module rem_front #(
  parameter int NUM_VARS  = rem_pkg::NUM_VARS_DEF,
  parameter int NUM_COMPS = rem_pkg::NUM_COMPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rem_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [rem_pkg::IN_USER_W-1:0]  in_user_i,
  input  logic                           in_last_i,
  output logic                           cmd_valid_o,
  output rem_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_ready_i
);

  localparam int QAW = (rem_pkg::QDEPTH > 1) ? $clog2(rem_pkg::QDEPTH) : 1;
  localparam int QCW = $clog2(rem_pkg::QDEPTH + 1);

  rem_pkg::cmd_t      entries_q [rem_pkg::QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]     count_q;
  rem_pkg::cmd_t      cmd_in;
  logic               keep;
  logic               push, pop;
  logic               var_ok, comp_ok;

  always_comb begin
    cmd_in.op     = rem_pkg::req_e'(in_user_i[2:0]);
    cmd_in.vidx   = in_data_i[3:0];
    cmd_in.cidx   = in_data_i[7:4];
    cmd_in.value  = $signed(in_data_i[39:8]);
    cmd_in.last   = in_last_i;
    cmd_in.warmup = in_user_i[3];
    var_ok  = (int'(in_data_i[3:0]) < NUM_VARS);
    comp_ok = (int'(in_data_i[7:4]) < NUM_COMPS);
    unique case (in_user_i[2:0]) inside
      rem_pkg::REQ_SAMPLE, rem_pkg::REQ_LOAD_K, rem_pkg::REQ_LOAD_KI: keep = var_ok;
      rem_pkg::REQ_LOAD_VEC:  keep = var_ok && comp_ok;
      rem_pkg::REQ_LOAD_EVI:  keep = comp_ok;
      rem_pkg::REQ_RESTART:   keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign in_ready_o  = (count_q != QCW'(rem_pkg::QDEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= QAW'((int'(wr_ptr_q) + 1) % rem_pkg::QDEPTH);
      if (pop)  rd_ptr_q <= QAW'((int'(rd_ptr_q) + 1) % rem_pkg::QDEPTH);
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= cmd_in;
  end

endmodule

// ===== rtl/rem_back.sv =====
// back end: table loads, robust ewma update, projections and t2 over one shared multiplier
// depends on rem_pkg
module rem_back #(
  parameter int NUM_VARS  = rem_pkg::NUM_VARS_DEF,
  parameter int NUM_COMPS = rem_pkg::NUM_COMPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            cmd_valid_i,
  input  rem_pkg::cmd_t                   cmd_i,
  output logic                            cmd_ready_o,
  output logic                            res_valid_o,
  output rem_pkg::res_t                   res_o,
  input  logic                            res_ready_i
);

  localparam int VW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int CIW = (NUM_COMPS > 1) ? $clog2(NUM_COMPS) : 1;
  localparam int CW  = $clog2(NUM_COMPS + 2);
  localparam int VD  = NUM_VARS * NUM_COMPS;
  localparam int AW  = (VD > 1) ? $clog2(VD) : 1;

  rem_pkg::st_e state_q, state_d;

  // configuration
  logic [rem_pkg::LAM_W-1:0]      lam_q;
  logic                           huber_q;
  logic [rem_pkg::CFG_DATA_W-1:0] limit_q;

  // tables and state
  logic signed [31:0] ewma_q  [NUM_VARS];
  logic [NUM_VARS-1:0] ewma_v_q;
  logic signed [31:0] kb_q    [NUM_VARS];
  logic signed [31:0] kinv_q  [NUM_VARS];
  logic signed [31:0] evi_q   [NUM_COMPS];
  logic signed [63:0] proj_q  [NUM_COMPS];
  logic [NUM_COMPS-1:0] proj_v_q;
  logic signed [31:0] vec_mem [VD];
  logic signed [31:0] vec_rd_q;
  logic [rem_pkg::RL_W-1:0] mon_count_q;
  logic               latched_q;

  // working registers
  rem_pkg::cmd_t      cmd_q;
  logic [CW-1:0]      cnt_q;
  logic signed [31:0] y_q, k_q, ki_q;
  logic signed [32:0] e_q;
  rem_pkg::phi_e      kind_q;
  logic signed [67:0] p_q;
  logic               big_q, neg_q;
  logic [31:0]        ar_q;
  logic [48:0]        sq_q;
  logic [64:0]        m1_q;
  logic signed [rem_pkg::ACC_W-1:0] acc_q;

  // combinational
  logic signed [33:0] mul_a, mul_b;
  logic signed [51:0] pq_sh;
  logic signed [17:0] d_s, r_sat, s_val;
  logic signed [18:0] t_val;
  logic signed [17:0] lam_s;
  logic [VW-1:0]      vi, cvi;
  logic [CIW-1:0]     pidx, tidx;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] y_rd;
  logic signed [32:0] e_new;
  logic signed [33:0] e_ext, k_ext;
  logic               e_lt, e_gt, in_band;
  logic [32:0]        e_abs;
  logic signed [39:0] q40, phi;
  logic signed [40:0] ysum;
  logic signed [31:0] y_new;
  logic signed [63:0] tp;
  logic [63:0]        ap;
  logic [48:0]        sq_d;
  logic [65:0]        term;
  logic [48:0]        term_c;
  logic [rem_pkg::T2_W-1:0] t2_val;
  logic               alarm_now, drop, sample_go, res_fire, proj_done;
  logic [rem_pkg::RL_W-1:0] count_new;

  assign vi      = VW'(cmd_q.vidx);
  assign cvi     = VW'(cmd_i.vidx);
  assign pidx    = CIW'(cnt_q - CW'(2));
  assign tidx    = CIW'(cnt_q);
  assign rd_addr = AW'(int'(vi) * NUM_COMPS + int'(cnt_q));
  assign wr_addr = AW'(int'(cvi) * NUM_COMPS + int'(cmd_i.cidx));
  assign pq_sh   = $signed(p_q[67:16]);
  assign lam_s   = $signed({1'b0, lam_q});
  assign d_s     = 18'sd65536 - lam_s;

  assign y_rd    = ewma_v_q[vi] ? ewma_q[vi] : 32'sd0;
  assign e_new   = 33'(cmd_q.value) - 33'(y_rd);
  assign e_ext   = 34'(e_q);
  assign k_ext   = 34'(k_q);
  assign e_lt    = e_ext < -k_ext;
  assign e_gt    = e_ext > k_ext;
  assign e_abs   = e_q[32] ? 33'(-e_q) : 33'(e_q);
  assign in_band = !k_q[31] && (e_abs <= 33'(k_q));

  always_comb begin
    if (pq_sh > 52'sd65536) r_sat = 18'sd65536;
    else if (pq_sh < -52'sd65536) r_sat = -18'sd65536;
    else r_sat = pq_sh[17:0];
  end
  assign s_val = 18'sd65536 - $signed(pq_sh[17:0]);
  assign t_val = 19'sd65536 - $signed(pq_sh[18:0]);

  assign q40 = pq_sh[39:0];
  always_comb begin
    case (kind_q)
      rem_pkg::PHI_ADD:  phi = 40'(e_q) + q40;
      rem_pkg::PHI_SUB:  phi = 40'(e_q) - q40;
      rem_pkg::PHI_PROD: phi = q40;
      default:           phi = 40'(e_q);
    endcase
  end
  assign ysum = 41'(y_q) + 41'(phi);
  always_comb begin
    if (ysum > 41'sd2147483647) y_new = 32'sh7FFFFFFF;
    else if (ysum < -41'sd2147483648) y_new = 32'sh80000000;
    else y_new = ysum[31:0];
  end

  assign tp   = proj_v_q[tidx] ? proj_q[tidx] : 64'sd0;
  assign ap   = tp[63] ? 64'(-tp) : 64'(tp);
  assign sq_d = big_q ? 49'h1_0000_0000_0000 : p_q[64:16];
  assign term = 66'(m1_q) + 66'(p_q[47:16]);
  assign term_c = (term > 66'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : term[48:0];

  always_comb begin
    if (acc_q < 0) t2_val = '0;
    else if (acc_q > $signed({8'b0, rem_pkg::T2_MAX})) t2_val = rem_pkg::T2_MAX;
    else t2_val = acc_q[rem_pkg::T2_W-1:0];
  end
  assign alarm_now = !cmd_q.warmup && (t2_val > limit_q);
  assign count_new = (cmd_q.warmup || mon_count_q == rem_pkg::RL_MAX) ? mon_count_q
                                                                      : mon_count_q + 1'b1;
  assign res_o.t2_stat    = t2_val;
  assign res_o.alarm      = alarm_now;
  assign res_o.run_length = count_new;
  assign res_o.was_warmup = cmd_q.warmup;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      rem_pkg::ST_SC: begin
        if (huber_q) begin
          if (e_lt || e_gt) begin
            mul_a = 34'(d_s);
            mul_b = k_ext;
          end else begin
            mul_a = 34'(lam_s);
            mul_b = e_ext;
          end
        end else begin
          mul_a = e_ext;
          mul_b = 34'(ki_q);
        end
      end
      rem_pkg::ST_B2: begin
        mul_a = 34'(r_sat);
        mul_b = 34'(r_sat);
      end
      rem_pkg::ST_B3: begin
        mul_a = 34'(s_val);
        mul_b = 34'(s_val);
      end
      rem_pkg::ST_B4: begin
        mul_a = 34'(d_s);
        mul_b = 34'($signed(pq_sh[17:0]));
      end
      rem_pkg::ST_B5: begin
        mul_a = e_ext;
        mul_b = 34'(t_val);
      end
      rem_pkg::ST_PROJ: begin
        mul_a = 34'(y_q);
        mul_b = 34'(vec_rd_q);
      end
      rem_pkg::ST_T_SQ: begin
        mul_a = $signed({2'b0, ap[31:0]});
        mul_b = $signed({2'b0, ap[31:0]});
      end
      rem_pkg::ST_T_M1: begin
        mul_a = $signed({1'b0, sq_d[48:16]});
        mul_b = $signed({2'b0, ar_q});
      end
      rem_pkg::ST_T_M2: begin
        mul_a = $signed({18'b0, sq_q[15:0]});
        mul_b = $signed({2'b0, ar_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign drop      = !cmd_i.warmup && latched_q;
  assign sample_go = cmd_valid_i && (cmd_i.op == rem_pkg::REQ_SAMPLE) && !drop;
  assign proj_done = (cnt_q == CW'(NUM_COMPS + 1));
  assign res_fire  = (state_q == rem_pkg::ST_RES) && res_ready_i;

  // next state and handshakes
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      rem_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (sample_go) state_d = rem_pkg::ST_ERR;
      end
      rem_pkg::ST_ERR:  state_d = (e_new == '0) ? rem_pkg::ST_PROJ : rem_pkg::ST_SC;
      rem_pkg::ST_SC:   state_d = (!huber_q && in_band) ? rem_pkg::ST_B2 : rem_pkg::ST_FIN;
      rem_pkg::ST_B2:   state_d = rem_pkg::ST_B3;
      rem_pkg::ST_B3:   state_d = rem_pkg::ST_B4;
      rem_pkg::ST_B4:   state_d = rem_pkg::ST_B5;
      rem_pkg::ST_B5:   state_d = rem_pkg::ST_FIN;
      rem_pkg::ST_FIN:  state_d = rem_pkg::ST_PROJ;
      rem_pkg::ST_PROJ: begin
        if (proj_done) state_d = cmd_q.last ? rem_pkg::ST_T_SQ : rem_pkg::ST_IDLE;
      end
      rem_pkg::ST_T_SQ: state_d = rem_pkg::ST_T_M1;
      rem_pkg::ST_T_M1: state_d = rem_pkg::ST_T_M2;
      rem_pkg::ST_T_M2: state_d = rem_pkg::ST_T_ACC;
      rem_pkg::ST_T_ACC: begin
        state_d = (cnt_q == CW'(NUM_COMPS - 1)) ? rem_pkg::ST_RES : rem_pkg::ST_T_SQ;
      end
      rem_pkg::ST_RES: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = rem_pkg::ST_IDLE;
      end
      default: state_d = rem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rem_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q       <= rem_pkg::LAMBDA_RST;
      huber_q     <= 1'b1;
      limit_q     <= rem_pkg::LIMIT_RST;
      ewma_v_q    <= '0;
      proj_v_q    <= '0;
      mon_count_q <= '0;
      latched_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rem_pkg::CFG_LAMBDA: lam_q   <= cfg_data_i[rem_pkg::LAM_W-1:0];
          rem_pkg::CFG_HUBER:  huber_q <= cfg_data_i[0];
          rem_pkg::CFG_LIMIT:  limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == rem_pkg::ST_IDLE && cmd_valid_i && cmd_i.op == rem_pkg::REQ_RESTART) begin
        ewma_v_q    <= '0;
        proj_v_q    <= '0;
        mon_count_q <= '0;
        latched_q   <= 1'b0;
      end
      if (state_q == rem_pkg::ST_FIN) ewma_v_q[vi] <= 1'b1;
      if (state_q == rem_pkg::ST_PROJ && cnt_q >= CW'(2)) proj_v_q[pidx] <= 1'b1;
      if (res_fire) begin
        proj_v_q    <= '0;
        mon_count_q <= count_new;
        if (alarm_now) latched_q <= 1'b1;
      end
      // the component index holds through the steps of one t2 term
      case (state_q) inside
        rem_pkg::ST_PROJ:  cnt_q <= proj_done ? '0 : cnt_q + 1'b1;
        rem_pkg::ST_T_ACC: cnt_q <= cnt_q + 1'b1;
        rem_pkg::ST_T_SQ, rem_pkg::ST_T_M1, rem_pkg::ST_T_M2: ;
        default:           cnt_q <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (state_q == rem_pkg::ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      case (cmd_i.op)
        rem_pkg::REQ_LOAD_K:   kb_q[cvi]   <= cmd_i.value;
        rem_pkg::REQ_LOAD_KI:  kinv_q[cvi] <= cmd_i.value;
        rem_pkg::REQ_LOAD_VEC: vec_mem[wr_addr] <= cmd_i.value;
        rem_pkg::REQ_LOAD_EVI: evi_q[CIW'(cmd_i.cidx)] <= cmd_i.value;
        default: ;
      endcase
    end
    if (int'(cnt_q) < NUM_COMPS) vec_rd_q <= vec_mem[rd_addr];
    case (state_q)
      rem_pkg::ST_ERR: begin
        y_q  <= y_rd;
        e_q  <= e_new;
        k_q  <= kb_q[vi];
        ki_q <= kinv_q[vi];
      end
      rem_pkg::ST_SC: begin
        if (!huber_q) kind_q <= in_band ? rem_pkg::PHI_PROD : rem_pkg::PHI_ERR;
        else if (e_lt) kind_q <= rem_pkg::PHI_ADD;
        else if (e_gt) kind_q <= rem_pkg::PHI_SUB;
        else kind_q <= rem_pkg::PHI_PROD;
      end
      rem_pkg::ST_FIN: begin
        y_q <= y_new;
        ewma_q[vi] <= y_new;
      end
      rem_pkg::ST_PROJ: begin
        if (cnt_q >= CW'(2)) begin
          proj_q[pidx] <= (proj_v_q[pidx] ? proj_q[pidx] : 64'sd0) + 64'(pq_sh);
        end
        acc_q <= '0;
      end
      rem_pkg::ST_T_SQ: begin
        big_q <= |ap[63:32];
        ar_q  <= evi_q[tidx][31] ? 32'(-evi_q[tidx]) : 32'(evi_q[tidx]);
        neg_q <= evi_q[tidx][31];
      end
      rem_pkg::ST_T_M1: sq_q <= sq_d;
      rem_pkg::ST_T_M2: m1_q <= p_q[64:0];
      rem_pkg::ST_T_ACC: begin
        if (neg_q) acc_q <= acc_q - $signed(rem_pkg::ACC_W'(term_c));
        else       acc_q <= acc_q + $signed(rem_pkg::ACC_W'(term_c));
      end
      default: ;
    endcase
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rem_pkg::ST_IDLE && cmd_valid_i && cmd_i.op == rem_pkg::REQ_RESTART)
      |=> (mon_count_q == '0 && !latched_q && ewma_v_q == '0))
    else $error("restart did not clear monitor state");

  a_warm_no_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.was_warmup) |-> !res_o.alarm)
    else $error("alarm raised on warm-up observation");

  a_alarm_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && res_o.alarm) |=> latched_q)
    else $error("alarm not latched");

  a_proj_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rem_pkg::ST_PROJ) |-> (int'(cnt_q) <= NUM_COMPS + 1))
    else $error("projection counter overran");

endmodule

// ===== tb/robust_ewma_t2_monitor_checker.sv =====
// watches the input, config and output channels of the robust ewma t2 monitor,
// predicts each T2 result and compares it field by field; depends on rem_pkg
module robust_ewma_t2_monitor_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rem_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // var_index[3:0], comp_index[7:4], value[39:8]
  input  logic [rem_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // req_type[2:0], warmup[3]
  input  logic [rem_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // t2_stat[47:0], alarm[48], run_length[64:49], zero fill above
  input  logic [rem_pkg::OUT_DATA_W-1:0]  m_axis_tdata_i,
  // was_warmup[0]
  input  logic                            m_axis_tuser_i,
  output int                              fail_cnt_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              alarms_o
);

  localparam longint ONE = 64'sd65536;

  rem_pkg::res_t t2_due_q[$];
  longint ewma_y[16];
  longint bound_k[16];
  longint bound_kinv[16];
  longint eig_vec[256];
  longint eig_inv[16];
  longint proj_acc[16];
  int unsigned mon_cnt;
  bit     latched;
  longint lam;
  bit     huber;
  logic [47:0] limit;

  assign pending_o = t2_due_q.size();

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint robust_score(longint e, longint k, longint kinv);
    longint d, r, s, s2, t, ae;
    d = ONE - lam;
    if (huber) begin
      if (e < -k) return e + qmul(d, k);
      if (e > k) return e - qmul(d, k);
      return qmul(lam, e);
    end
    ae = (e < 0) ? -e : e;
    if (ae <= k) begin
      r = qmul(e, kinv);
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      s = ONE - qmul(r, r);
      s2 = qmul(s, s);
      t = ONE - qmul(d, s2);
      return qmul(e, t);
    end
    return e;
  endfunction

  function automatic logic [47:0] t2_of_proj();
    longint acc, p, rs;
    bit [63:0] ap, ar, sq, term;
    acc = 0;
    for (int c = 0; c < 16; c++) begin
      p = proj_acc[c];
      ap = (p < 0) ? 64'(-p) : 64'(p);
      rs = eig_inv[c];
      ar = (rs < 0) ? 64'(-rs) : 64'(rs);
      if (ap >= 64'h1_0000_0000) sq = 64'd1 << 48;
      else sq = (ap * ap) >> 16;
      term = (sq >> 16) * ar + (((sq & 64'hFFFF) * ar) >> 16);
      if (term > (64'd1 << 48)) term = 64'd1 << 48;
      if (rs < 0) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) return '0;
    if (acc > longint'(64'hFFFF_FFFF_FFFF)) return rem_pkg::T2_MAX;
    return acc[47:0];
  endfunction

  task automatic predict_beat(logic [2:0] req, logic [3:0] vi, logic [3:0] ci,
                              logic [31:0] val, bit last, bit warm);
    longint y, e;
    rem_pkg::res_t r;
    case (req)
      rem_pkg::REQ_LOAD_K:   bound_k[vi] = longint'($signed(val));
      rem_pkg::REQ_LOAD_KI:  bound_kinv[vi] = longint'($signed(val));
      rem_pkg::REQ_LOAD_VEC: eig_vec[{vi, ci}] = longint'($signed(val));
      rem_pkg::REQ_LOAD_EVI: eig_inv[ci] = longint'($signed(val));
      rem_pkg::REQ_RESTART: begin
        foreach (ewma_y[i]) ewma_y[i] = 0;
        foreach (proj_acc[i]) proj_acc[i] = 0;
        mon_cnt = 0;
        latched = 0;
      end
      rem_pkg::REQ_SAMPLE: begin
        if (!warm && latched) return;
        y = ewma_y[vi];
        e = longint'($signed(val)) - y;
        if (e != 0) begin
          y = y + robust_score(e, bound_k[vi], bound_kinv[vi]);
          if (y > 64'sd2147483647) y = 64'sd2147483647;
          if (y < -64'sd2147483648) y = -64'sd2147483648;
          ewma_y[vi] = y;
        end
        for (int c = 0; c < 16; c++) proj_acc[c] += qmul(y, eig_vec[{vi, 4'(c)}]);
        if (!last) return;
        r.t2_stat = t2_of_proj();
        r.alarm = 1'b0;
        foreach (proj_acc[i]) proj_acc[i] = 0;
        if (!warm) begin
          if (mon_cnt < 65535) mon_cnt++;
          if (r.t2_stat > limit) begin
            r.alarm = 1'b1;
            latched = 1;
          end
        end
        r.run_length = mon_cnt[15:0];
        r.was_warmup = warm;
        t2_due_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_due_q.delete();
      foreach (ewma_y[i]) begin
        ewma_y[i] = 0; bound_k[i] = 0; bound_kinv[i] = 0; eig_inv[i] = 0; proj_acc[i] = 0;
      end
      foreach (eig_vec[i]) eig_vec[i] = 0;
      mon_cnt = 0;
      latched = 0;
      lam = longint'(rem_pkg::LAMBDA_RST);
      huber = 1;
      limit = rem_pkg::LIMIT_RST;
      fail_cnt_o = 0;
      results_o = 0;
      alarms_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rem_pkg::CFG_LAMBDA: lam = longint'(cfg_data_i[rem_pkg::LAM_W-1:0]);
          rem_pkg::CFG_HUBER:  huber = cfg_data_i[0];
          rem_pkg::CFG_LIMIT:  limit = cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_beat(s_axis_tuser_i[2:0], s_axis_tdata_i[3:0], s_axis_tdata_i[7:4],
                     s_axis_tdata_i[39:8], s_axis_tlast_i, s_axis_tuser_i[3]);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o++;
        if (m_axis_tdata_i[48]) alarms_o++;
        if (t2_due_q.size() == 0) begin
          $display("%0t: unexpected result beat t2=%h", $time, m_axis_tdata_i[47:0]);
          fail_cnt_o++;
        end else begin
          rem_pkg::res_t x;
          x = t2_due_q.pop_front();
          if (x.t2_stat !== m_axis_tdata_i[47:0] || x.alarm !== m_axis_tdata_i[48] ||
              x.run_length !== m_axis_tdata_i[64:49] || x.was_warmup !== m_axis_tuser_i) begin
            $display("%0t: mismatch exp t2=%h alarm=%0d rl=%0d warm=%0d", $time,
                     x.t2_stat, x.alarm, x.run_length, x.was_warmup);
            $display("%0t:          got t2=%h alarm=%0d rl=%0d warm=%0d", $time,
                     m_axis_tdata_i[47:0], m_axis_tdata_i[48], m_axis_tdata_i[64:49],
                     m_axis_tuser_i);
            fail_cnt_o++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_robust_ewma_t2_monitor.sv =====
// stimulus and verdict for the robust ewma t2 monitor: table loads, directed and
// random observations under several idle settings; depends on rem_pkg and the checker
module tb_robust_ewma_t2_monitor;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [rem_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [rem_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [rem_pkg::IN_DATA_W-1:0] s_data = '0;
  logic [rem_pkg::IN_USER_W-1:0] s_user = '0;
  logic s_last = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [rem_pkg::OUT_DATA_W-1:0] m_data;
  logic m_user;
  int fail_cnt, pending, results, alarms;
  int src_idle = 0, sink_stall = 0, beats = 0;

  always #6 clk_i = ~clk_i;

  robust_ewma_t2_monitor i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user)
  );

  robust_ewma_t2_monitor_checker i_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .m_axis_tuser_i(m_user),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .results_o(results), .alarms_o(alarms)
  );

  always @(posedge clk_i) m_ready <= ($urandom_range(99) >= sink_stall);

  task automatic send_beat(logic [2:0] req, logic [3:0] vi, logic [3:0] ci,
                           logic [31:0] val, bit last, bit warm);
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {val, ci, vi};
    s_user <= {warm, req};
    s_last <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    beats++;
  endtask

  // drained and quiet before any register write
  task automatic wait_quiet();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(rem_pkg::cfg_e idx, logic [rem_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] sample_val();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
    endcase
  endfunction

  task automatic load_bound(logic [3:0] vi);
    logic [31:0] k;
    case ($urandom_range(7))
      0: k = $urandom;
      1: k = 32'($signed(-$urandom_range(1, 32'h4_0000)));
      default: k = $urandom_range(32'h4000, 32'h8_0000);
    endcase
    send_beat(rem_pkg::REQ_LOAD_K, vi, 4'd0, k, 1'($urandom_range(1)),
              1'($urandom_range(1)));
    send_beat(rem_pkg::REQ_LOAD_KI, vi, 4'd0,
              (k[31] || k == 0) ? $urandom : 32'(64'h1_0000_0000 / k), 1'b0, 1'b0);
  endtask

  task automatic load_vec(logic [3:0] vi, logic [3:0] ci);
    send_beat(rem_pkg::REQ_LOAD_VEC, vi, ci,
              ($urandom_range(15) == 0) ? $urandom
                : 32'($signed($urandom_range(0, 32'h2_0000))) - 32'sh1_0000,
              1'b0, 1'b0);
  endtask

  task automatic load_inv_eig(logic [3:0] ci);
    send_beat(rem_pkg::REQ_LOAD_EVI, 4'd0, ci,
              ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 32'h2_0000),
              1'b0, 1'b0);
  endtask

  task automatic observation(bit warm);
    int nv;
    nv = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 4);
    for (int i = 0; i < nv; i++)
      send_beat(rem_pkg::REQ_SAMPLE, 4'($urandom), 4'($urandom), sample_val(),
                i == nv - 1, warm);
  endtask

  task automatic random_phase(int n_items);
    int stop;
    stop = beats + n_items;
    while (beats < stop) begin
      case ($urandom_range(19)) inside
        0: send_beat(rem_pkg::REQ_RESTART, 4'($urandom), 4'($urandom), $urandom,
                     1'($urandom), 1'($urandom));
        1: load_vec(4'($urandom), 4'($urandom));
        2: load_bound(4'($urandom));
        3: load_inv_eig(4'($urandom));
        4: send_beat($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B, 4'($urandom),
                     4'($urandom), $urandom, 1'($urandom), 1'($urandom));
        5: send_beat(rem_pkg::REQ_SAMPLE, 4'($urandom), 4'($urandom), sample_val(),
                     1'b0, 1'b0);
        6, 7, 8: observation(1'b1);
        default: observation(1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every table entry is loaded before any sample reads it
    for (int v = 0; v < 16; v++) load_bound(4'(v));
    for (int v = 0; v < 16; v++)
      for (int c = 0; c < 16; c++) load_vec(4'(v), 4'(c));
    for (int c = 0; c < 16; c++) load_inv_eig(4'(c));

    // directed: zero error, extremes, warm-up, unused kinds, restart
    send_beat(rem_pkg::REQ_SAMPLE, 4'd0, 4'd0, 32'd0, 1'b1, 1'b1);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd15, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd15, 4'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd3, 4'd9, 32'h8000_0000, 1'b1, 1'b0);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd3, 4'd9, 32'h0001_0000, 1'b1, 1'b0);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd3, 4'd9, 32'h0001_0000, 1'b1, 1'b1);
    send_beat(REQ_SPARE_A, 4'd1, 4'd1, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_beat(REQ_SPARE_B, 4'd2, 4'd2, 32'h0, 1'b1, 1'b1);
    send_beat(rem_pkg::REQ_RESTART, 4'd0, 4'd0, 32'h0, 1'b0, 1'b0);
    send_beat(rem_pkg::REQ_SAMPLE, 4'd7, 4'd0, 32'h0000_8000, 1'b1, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 58; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 58; end
        3: begin src_idle = 23; sink_stall = 23; end
        4: begin src_idle = 0;  sink_stall = 0;  end
        default: begin src_idle = 23; sink_stall = 58; end
      endcase
      case (ph)
        0: write_reg(rem_pkg::CFG_LAMBDA, 48'd65536);
        1: write_reg(rem_pkg::CFG_LAMBDA, 48'd0);
        default: write_reg(rem_pkg::CFG_LAMBDA, 48'($urandom_range(0, 65536)));
      endcase
      write_reg(rem_pkg::CFG_HUBER, 48'(ph[0]));
      case (ph)
        0: write_reg(rem_pkg::CFG_LIMIT, 48'hFFFF_FFFF_FFFF);
        1: write_reg(rem_pkg::CFG_LIMIT, 48'd0);
        default: write_reg(rem_pkg::CFG_LIMIT, {16'd0, $urandom});
      endcase
      send_beat(rem_pkg::REQ_RESTART, 4'd0, 4'd0, 32'd0, 1'b0, 1'b0);
      random_phase(100);
    end

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input beats, %0d results, %0d alarms", beats, results, alarms);
    $display("over 6 register settings incl. lambda and limit extremes, both scores");
    if (fail_cnt == 0) begin
      $display("tb_robust_ewma_t2_monitor: PASS");
    end else begin
      $display("tb_robust_ewma_t2_monitor: FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("timeout with %0d results still due", pending);
    $display("tb_robust_ewma_t2_monitor: FAIL");
    $finish;
  end

endmodule
